// ===== hdl/cpbb_pkg.sv =====
`timescale 1ns / 1ps

package cpbb_pkg;

    localparam int COORD_W = 32;
    localparam int T_BITS  = 16;
    localparam int COEF_W  = 36;
    localparam int MAG_W   = 35;
    localparam int NORM_W  = 32;
    localparam int ROOT_W  = 34;
    localparam int DISC_W  = 64;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + T_BITS;

    localparam logic [1:0] REQ_MOVE  = 2'd0;
    localparam logic [1:0] REQ_LINE  = 2'd1;
    localparam logic [1:0] REQ_CURVE = 2'd2;
    localparam logic [1:0] REQ_CLOSE = 2'd3;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [COORD_W-1:0]  pt_a_x;
        logic signed [COORD_W-1:0]  pt_a_y;
        logic signed [COORD_W-1:0]  pt_b_x;
        logic signed [COORD_W-1:0]  pt_b_y;
        logic signed [COORD_W-1:0]  pt_c_x;
        logic signed [COORD_W-1:0]  pt_c_y;
        logic                       last_command;
    } t_cmd_word;

    typedef struct packed {
        logic signed [COORD_W-1:0]  box_min_x;
        logic signed [COORD_W-1:0]  box_min_y;
        logic signed [COORD_W-1:0]  box_max_x;
        logic signed [COORD_W-1:0]  box_max_y;
    } t_box_word;

    typedef enum logic [1:0] {
        JOB_MOVE,
        JOB_SEGMENT,
        JOB_CURVE
    } t_job_kind;

    typedef struct packed {
        t_job_kind                  kind;
        logic                       last;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASIC,
        S_COEF,
        S_NORM,
        S_DECIDE,
        S_MUL_AC,
        S_DISC,
        S_SQRT,
        S_SQRT_DONE,
        S_ROOT_CHECK,
        S_DIV,
        S_EVAL,
        S_ADD_ROOT,
        S_NEXT_ROOT,
        S_AXIS_END,
        S_FINISH
    } t_seq_state;

endpackage

// ===== hdl/cpbb_front.sv =====
`timescale 1ns / 1ps

module cpbb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpbb_pkg::t_cmd_word i_in_word,
    output logic                o_job_valid,
    output cpbb_pkg::t_job      o_job,
    input  logic                i_job_pop
);

    cpbb_pkg::t_job  r_q [0:1];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    cpbb_pkg::t_job  w_job;
    logic            w_push;

    always_comb begin
        w_job.last = i_in_word.last_command;
        w_job.ax   = i_in_word.pt_a_x;
        w_job.ay   = i_in_word.pt_a_y;
        w_job.bx   = i_in_word.pt_b_x;
        w_job.by   = i_in_word.pt_b_y;
        w_job.cx   = i_in_word.pt_c_x;
        w_job.cy   = i_in_word.pt_c_y;
        case (i_in_word.req_type)
            cpbb_pkg::REQ_MOVE:  w_job.kind = cpbb_pkg::JOB_MOVE;
            cpbb_pkg::REQ_CURVE: w_job.kind = cpbb_pkg::JOB_CURVE;
            cpbb_pkg::REQ_LINE:  w_job.kind = cpbb_pkg::JOB_SEGMENT;
            cpbb_pkg::REQ_CLOSE: w_job.kind = cpbb_pkg::JOB_SEGMENT;
            default:             w_job.kind = cpbb_pkg::JOB_SEGMENT;
        endcase
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign w_push      = i_in_valid && o_in_ready;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_job_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_job_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

// ===== hdl/cpbb_back.sv =====
`timescale 1ns / 1ps

module cpbb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  cpbb_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_out_free,
    output logic                o_box_valid,
    output cpbb_pkg::t_box_word o_box
);

    localparam int CW = cpbb_pkg::COORD_W;
    localparam int KW = cpbb_pkg::COEF_W;
    localparam int MW = cpbb_pkg::MAG_W;
    localparam int NW = cpbb_pkg::NORM_W;
    localparam int RW = cpbb_pkg::ROOT_W;
    localparam int DW = cpbb_pkg::DISC_W;
    localparam int TW = cpbb_pkg::T_BITS;
    localparam int FW = cpbb_pkg::DIFF_W;
    localparam int PW = cpbb_pkg::PROD_W;
    localparam logic [MW-1:0] NORM_HI = MW'(1) << 30;
    localparam logic [MW-1:0] NORM_LO = MW'(1) << 29;

    cpbb_pkg::t_seq_state r_state;
    cpbb_pkg::t_seq_state n_state;

    cpbb_pkg::t_job       r_job;
    logic signed [CW-1:0] r_p0x, r_p0y, r_cur_x, r_cur_y;
    logic signed [CW-1:0] r_low_x, r_low_y, r_high_x, r_high_y;
    logic                 r_have;
    logic                 r_axis;
    logic [MW-1:0]        r_ma, r_mh, r_mc;
    logic                 r_sa, r_sh, r_sc;
    logic signed [DW-1:0] r_prod_hh, r_prod_ac;
    logic [DW-1:0]        r_v, r_s;
    logic [4:0]           r_k;
    logic signed [RW-1:0] r_n1, r_n2, r_d;
    logic                 r_has2;
    logic [RW-1:0]        r_rem, r_dd;
    logic [TW-1:0]        r_q;
    logic [3:0]           r_cnt;
    logic                 r_ev_axis;
    logic [2:0]           r_step;
    logic                 r_phase;
    logic signed [CW-1:0] r_q0, r_q1, r_q2, r_r0, r_r1, r_ex, r_ey, r_lp_p;
    logic [FW-1:0]        r_lp_m;
    logic                 r_lp_neg;

    // Control points of the axis under root search.
    logic signed [CW-1:0] w_c0, w_c1, w_c2, w_c3;
    logic signed [KW-1:0] w_k0, w_k1, w_k2, w_k3, w_ka, w_kh, w_kc;
    logic [MW-1:0]        w_m;
    logic                 w_shr, w_shl;
    logic signed [NW-1:0] w_na, w_nh, w_nc;
    logic signed [RW-1:0] w_nh34, w_nc34, w_s34;
    logic signed [NW-1:0] w_mul_x, w_mul_y;
    logic signed [DW-1:0] w_mul, w_disc;
    logic [DW-1:0]        w_bit, w_sb;
    logic signed [RW-1:0] w_rc_n, w_rc_d;
    logic                 w_root_ok;
    logic [RW:0]          w_rem2;
    logic                 w_ge;
    logic signed [CW-1:0] w_e0, w_e1, w_e2, w_e3, w_lp_a, w_lp_b;
    logic signed [FW-1:0] w_lp_d;
    logic [FW-1:0]        w_lp_mag;
    logic [PW-1:0]        w_lp_prod;
    logic signed [RW-1:0] w_lp_res;
    logic signed [CW-1:0] w_res;
    logic                 w_add_en;
    logic signed [CW-1:0] w_seed_x, w_seed_y, w_pt_x, w_pt_y;
    logic signed [CW-1:0] w_blx, w_bly, w_bhx, w_bhy;

    // Derivative coefficients a, h, c of one axis.
    always_comb begin
        w_c0 = r_axis ? r_p0y    : r_p0x;
        w_c1 = r_axis ? r_job.ay : r_job.ax;
        w_c2 = r_axis ? r_job.by : r_job.bx;
        w_c3 = r_axis ? r_job.cy : r_job.cx;
        w_k0 = KW'(w_c0);
        w_k1 = KW'(w_c1);
        w_k2 = KW'(w_c2);
        w_k3 = KW'(w_c3);
        w_ka = w_k3 - w_k0 + ((w_k1 - w_k2) <<< 1) + (w_k1 - w_k2);
        w_kh = w_k0 - (w_k1 <<< 1) + w_k2;
        w_kc = w_k1 - w_k0;
    end

    always_comb begin
        w_m = r_ma;
        if (r_mh > w_m) begin
            w_m = r_mh;
        end
        if (r_mc > w_m) begin
            w_m = r_mc;
        end
    end
    assign w_shr = (w_m >= NORM_HI);
    assign w_shl = (w_m < NORM_LO);

    assign w_na = r_sa ? -$signed({1'b0, r_ma[30:0]}) : $signed({1'b0, r_ma[30:0]});
    assign w_nh = r_sh ? -$signed({1'b0, r_mh[30:0]}) : $signed({1'b0, r_mh[30:0]});
    assign w_nc = r_sc ? -$signed({1'b0, r_mc[30:0]}) : $signed({1'b0, r_mc[30:0]});
    assign w_nh34 = RW'(w_nh);
    assign w_nc34 = RW'(w_nc);
    assign w_s34  = $signed({3'b000, r_s[30:0]});

    // One shared multiplier: h*h, then a*c on the next cycle.
    assign w_mul_x = (r_state == cpbb_pkg::S_DECIDE) ? w_nh : w_na;
    assign w_mul_y = (r_state == cpbb_pkg::S_DECIDE) ? w_nh : w_nc;
    assign w_mul   = w_mul_x * w_mul_y;
    assign w_disc  = r_prod_hh - r_prod_ac;

    assign w_bit = DW'(1) << {r_k, 1'b0};
    assign w_sb  = r_s + w_bit;

    assign w_rc_n    = (r_d < 0) ? -r_n1 : r_n1;
    assign w_rc_d    = (r_d < 0) ? -r_d  : r_d;
    assign w_root_ok = (w_rc_n > 0) && (w_rc_n < w_rc_d);

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_dd});

    // De Casteljau operand selection, one interpolation per step.
    always_comb begin
        w_e0 = r_ev_axis ? r_p0y    : r_p0x;
        w_e1 = r_ev_axis ? r_job.ay : r_job.ax;
        w_e2 = r_ev_axis ? r_job.by : r_job.bx;
        w_e3 = r_ev_axis ? r_job.cy : r_job.cx;
        case (r_step)
            3'd0:    begin w_lp_a = w_e0; w_lp_b = w_e1; end
            3'd1:    begin w_lp_a = w_e1; w_lp_b = w_e2; end
            3'd2:    begin w_lp_a = w_e2; w_lp_b = w_e3; end
            3'd3:    begin w_lp_a = r_q0; w_lp_b = r_q1; end
            3'd4:    begin w_lp_a = r_q1; w_lp_b = r_q2; end
            default: begin w_lp_a = r_r0; w_lp_b = r_r1; end
        endcase
    end

    assign w_lp_d    = FW'(w_lp_b) - FW'(w_lp_a);
    assign w_lp_mag  = (w_lp_d < 0) ? FW'(-w_lp_d) : FW'(w_lp_d);
    assign w_lp_prod = w_lp_mag * r_q;
    assign w_lp_res  = r_lp_neg ? (RW'(r_lp_p) - $signed({1'b0, r_lp_m}))
                                : (RW'(r_lp_p) + $signed({1'b0, r_lp_m}));
    assign w_res     = w_lp_res[CW-1:0];

    // Box update: an empty box starts from the seed point.
    always_comb begin
        w_add_en = 1'b0;
        w_seed_x = r_cur_x;
        w_seed_y = r_cur_y;
        w_pt_x   = r_ex;
        w_pt_y   = r_ey;
        case (r_state)
            cpbb_pkg::S_BASIC: begin
                w_add_en = 1'b1;
                case (r_job.kind)
                    cpbb_pkg::JOB_MOVE: begin
                        w_seed_x = r_job.ax;
                        w_seed_y = r_job.ay;
                        w_pt_x   = r_job.ax;
                        w_pt_y   = r_job.ay;
                    end
                    cpbb_pkg::JOB_CURVE: begin
                        w_pt_x = r_job.cx;
                        w_pt_y = r_job.cy;
                    end
                    default: begin
                        w_pt_x = r_job.ax;
                        w_pt_y = r_job.ay;
                    end
                endcase
            end
            cpbb_pkg::S_ADD_ROOT: begin
                w_add_en = 1'b1;
            end
            default: begin
                w_add_en = 1'b0;
            end
        endcase
        w_blx = r_have ? r_low_x  : w_seed_x;
        w_bly = r_have ? r_low_y  : w_seed_y;
        w_bhx = r_have ? r_high_x : w_seed_x;
        w_bhy = r_have ? r_high_y : w_seed_y;
        if (w_pt_x < w_blx) w_blx = w_pt_x;
        if (w_pt_y < w_bly) w_bly = w_pt_y;
        if (w_pt_x > w_bhx) w_bhx = w_pt_x;
        if (w_pt_y > w_bhy) w_bhy = w_pt_y;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cpbb_pkg::S_IDLE: begin
                if (i_job_valid) n_state = cpbb_pkg::S_BASIC;
            end
            cpbb_pkg::S_BASIC: begin
                n_state = (r_job.kind == cpbb_pkg::JOB_CURVE) ? cpbb_pkg::S_COEF
                                                              : cpbb_pkg::S_FINISH;
            end
            cpbb_pkg::S_COEF: begin
                n_state = ((w_ka == 0) && (w_kh == 0) && (w_kc == 0)) ?
                          cpbb_pkg::S_AXIS_END : cpbb_pkg::S_NORM;
            end
            cpbb_pkg::S_NORM: begin
                if (!w_shr && !w_shl) n_state = cpbb_pkg::S_DECIDE;
            end
            cpbb_pkg::S_DECIDE: begin
                if (w_na != 0) begin
                    n_state = cpbb_pkg::S_MUL_AC;
                end else if (w_nh != 0) begin
                    n_state = cpbb_pkg::S_ROOT_CHECK;
                end else begin
                    n_state = cpbb_pkg::S_AXIS_END;
                end
            end
            cpbb_pkg::S_MUL_AC: n_state = cpbb_pkg::S_DISC;
            cpbb_pkg::S_DISC: begin
                n_state = (w_disc < 0) ? cpbb_pkg::S_AXIS_END : cpbb_pkg::S_SQRT;
            end
            cpbb_pkg::S_SQRT: begin
                if (r_k == 5'd0) n_state = cpbb_pkg::S_SQRT_DONE;
            end
            cpbb_pkg::S_SQRT_DONE: n_state = cpbb_pkg::S_ROOT_CHECK;
            cpbb_pkg::S_ROOT_CHECK: begin
                n_state = w_root_ok ? cpbb_pkg::S_DIV : cpbb_pkg::S_NEXT_ROOT;
            end
            cpbb_pkg::S_DIV: begin
                if (r_cnt == 4'd0) n_state = cpbb_pkg::S_EVAL;
            end
            cpbb_pkg::S_EVAL: begin
                if (r_phase && (r_step == 3'd5) && r_ev_axis) n_state = cpbb_pkg::S_ADD_ROOT;
            end
            cpbb_pkg::S_ADD_ROOT: n_state = cpbb_pkg::S_NEXT_ROOT;
            cpbb_pkg::S_NEXT_ROOT: begin
                n_state = r_has2 ? cpbb_pkg::S_ROOT_CHECK : cpbb_pkg::S_AXIS_END;
            end
            cpbb_pkg::S_AXIS_END: begin
                n_state = r_axis ? cpbb_pkg::S_FINISH : cpbb_pkg::S_COEF;
            end
            cpbb_pkg::S_FINISH: begin
                if (!r_job.last || i_out_free) n_state = cpbb_pkg::S_IDLE;
            end
            default: n_state = cpbb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop       = (r_state == cpbb_pkg::S_IDLE) && i_job_valid;
        o_box_valid     = (r_state == cpbb_pkg::S_FINISH) && r_job.last && i_out_free;
        o_box.box_min_x = r_low_x;
        o_box.box_min_y = r_low_y;
        o_box.box_max_x = r_high_x;
        o_box.box_max_y = r_high_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cpbb_pkg::S_IDLE;
            r_have   <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_low_x  <= '0;
            r_low_y  <= '0;
            r_high_x <= '0;
            r_high_y <= '0;
        end else begin
            r_state <= n_state;
            if (o_box_valid) begin
                r_have   <= 1'b0;
                r_cur_x  <= '0;
                r_cur_y  <= '0;
                r_low_x  <= '0;
                r_low_y  <= '0;
                r_high_x <= '0;
                r_high_y <= '0;
            end else begin
                if (w_add_en) begin
                    r_have   <= 1'b1;
                    r_low_x  <= w_blx;
                    r_low_y  <= w_bly;
                    r_high_x <= w_bhx;
                    r_high_y <= w_bhy;
                end
                if (r_state == cpbb_pkg::S_BASIC) begin
                    r_cur_x <= (r_job.kind == cpbb_pkg::JOB_CURVE) ? r_job.cx : r_job.ax;
                    r_cur_y <= (r_job.kind == cpbb_pkg::JOB_CURVE) ? r_job.cy : r_job.ay;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cpbb_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    r_job  <= i_job;
                    r_p0x  <= r_cur_x;
                    r_p0y  <= r_cur_y;
                    r_axis <= 1'b0;
                end
            end
            cpbb_pkg::S_COEF: begin
                r_sa <= (w_ka < 0);
                r_sh <= (w_kh < 0);
                r_sc <= (w_kc < 0);
                r_ma <= (w_ka < 0) ? MW'(-w_ka) : MW'(w_ka);
                r_mh <= (w_kh < 0) ? MW'(-w_kh) : MW'(w_kh);
                r_mc <= (w_kc < 0) ? MW'(-w_kc) : MW'(w_kc);
            end
            cpbb_pkg::S_NORM: begin
                if (w_shr) begin
                    r_ma <= r_ma >> 1;
                    r_mh <= r_mh >> 1;
                    r_mc <= r_mc >> 1;
                end else if (w_shl) begin
                    r_ma <= r_ma << 1;
                    r_mh <= r_mh << 1;
                    r_mc <= r_mc << 1;
                end
            end
            cpbb_pkg::S_DECIDE: begin
                r_prod_hh <= w_mul;
                r_n1      <= -w_nc34;
                r_d       <= w_nh34 <<< 1;
                r_has2    <= 1'b0;
            end
            cpbb_pkg::S_MUL_AC: begin
                r_prod_ac <= w_mul;
            end
            cpbb_pkg::S_DISC: begin
                r_v <= DW'(w_disc);
                r_s <= '0;
                r_k <= 5'd31;
            end
            cpbb_pkg::S_SQRT: begin
                if (r_v >= w_sb) begin
                    r_v <= r_v - w_sb;
                    r_s <= (r_s >> 1) + w_bit;
                end else begin
                    r_s <= r_s >> 1;
                end
                r_k <= r_k - 5'd1;
            end
            cpbb_pkg::S_SQRT_DONE: begin
                r_n1   <= w_s34 - w_nh34;
                r_n2   <= -w_nh34 - w_s34;
                r_d    <= RW'(w_na);
                r_has2 <= 1'b1;
            end
            cpbb_pkg::S_ROOT_CHECK: begin
                r_rem <= RW'(w_rc_n);
                r_dd  <= RW'(w_rc_d);
                r_q   <= '0;
                r_cnt <= 4'd15;
            end
            cpbb_pkg::S_DIV: begin
                r_rem     <= w_ge ? RW'(w_rem2 - {1'b0, r_dd}) : w_rem2[RW-1:0];
                r_q       <= {r_q[TW-2:0], w_ge};
                r_cnt     <= r_cnt - 4'd1;
                r_ev_axis <= 1'b0;
                r_step    <= 3'd0;
                r_phase   <= 1'b0;
            end
            cpbb_pkg::S_EVAL: begin
                if (!r_phase) begin
                    r_lp_p   <= w_lp_a;
                    r_lp_neg <= (w_lp_d < 0);
                    r_lp_m   <= w_lp_prod[PW-1:TW];
                    r_phase  <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    case (r_step)
                        3'd0:    r_q0 <= w_res;
                        3'd1:    r_q1 <= w_res;
                        3'd2:    r_q2 <= w_res;
                        3'd3:    r_r0 <= w_res;
                        3'd4:    r_r1 <= w_res;
                        default: begin
                            if (r_ev_axis) begin
                                r_ey <= w_res;
                            end else begin
                                r_ex <= w_res;
                            end
                        end
                    endcase
                    if (r_step == 3'd5) begin
                        r_step    <= 3'd0;
                        r_ev_axis <= 1'b1;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
            end
            cpbb_pkg::S_NEXT_ROOT: begin
                r_n1   <= r_n2;
                r_has2 <= 1'b0;
            end
            cpbb_pkg::S_AXIS_END: begin
                r_axis <= 1'b1;
            end
            default: begin
                r_axis <= r_axis;
            end
        endcase
    end

endmodule

// ===== hdl/cubic_path_bounding_box.sv =====
// Bounding box of a path of move, line, cubic curve and close commands in signed
// Q16.16. Command words enter a two-word queue and are worked off by a sequencer;
// the box word appears on the output after the word marked last, and the path
// state is then cleared. A curve adds, per axis, coefficient normalization
// (one bit a cycle), the discriminant and the bit-pair square root, and for
// each root inside the curve a 16-step divider, then 12 interpolations on one
// 33x16 multiplier; the root search is skipped when all control points are
// equal and is longest with two roots on each axis. A last word also waits in
// the sequencer while the output register still holds an untaken box.
`timescale 1ns / 1ps

module cubic_path_bounding_box (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cpbb_pkg::t_cmd_word i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cpbb_pkg::t_box_word o_out_word
);

    logic                 w_job_valid;
    cpbb_pkg::t_job       w_job;
    logic                 w_job_pop;
    logic                 w_out_free;
    logic                 w_box_valid;
    cpbb_pkg::t_box_word  w_box;
    logic                 r_out_valid;
    cpbb_pkg::t_box_word  r_out_word;

    cpbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    cpbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .i_out_free  (w_out_free),
        .o_box_valid (w_box_valid),
        .o_box       (w_box)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_box_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_box_valid) begin
            r_out_word <= w_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hdl/cpbb_checker.sv =====
`timescale 1ns / 1ps

module cpbb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input cpbb_pkg::t_box_word o_out_word
);

    // A held box word must not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("box word changed while stalled");

    // The box is never inverted.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.box_min_x <= o_out_word.box_max_x)
                     && (o_out_word.box_min_y <= o_out_word.box_max_y))
        else $error("box minimum above maximum");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind cubic_path_bounding_box cpbb_checker u_cpbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    cpbb_pkg::t_cmd_word i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    cpbb_pkg::t_box_word o_out_word;

    cubic_path_bounding_box DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Predictor state of the path tracker.
    longint              cur_x, cur_y, lo_x, lo_y, hi_x, hi_y;
    bit                  seeded;
    cpbb_pkg::t_box_word box_queue[$];
    int                  fail_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  recv_hold;

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void grow_box(longint x, longint y);
        if (x < lo_x) lo_x = x;
        if (y < lo_y) lo_y = y;
        if (x > hi_x) hi_x = x;
        if (y > hi_y) hi_y = y;
    endfunction

    function automatic void seed_box();
        if (!seeded) begin
            lo_x = cur_x;
            hi_x = cur_x;
            lo_y = cur_y;
            hi_y = cur_y;
            seeded = 1'b1;
        end
    endfunction

    function automatic longint interp(longint p, longint q, longint t);
        longint d;
        longint m;
        d = q - p;
        m = (magn(d) * t) >>> cpbb_pkg::T_BITS;
        return (d < 0) ? p - m : p + m;
    endfunction

    function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                        longint t);
        longint q0, q1, q2, r0, r1;
        q0 = interp(p0, p1, t);
        q1 = interp(p1, p2, t);
        q2 = interp(p2, p3, t);
        r0 = interp(q0, q1, t);
        r1 = interp(q1, q2, t);
        return interp(r0, r1, t);
    endfunction

    // Appends t = n/d in Q0.16 when strictly inside the curve.
    function automatic void push_param(longint n, longint d, ref longint ts[$]);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n > 0 && n < d) ts = {ts, (n << cpbb_pkg::T_BITS) / d};
    endfunction

    function automatic void axis_extrema(longint p0, longint p1, longint p2, longint p3,
                                         ref longint ts[$]);
        longint a, h, c, ma, mh, mc, m, disc, s, b, bit_v;
        bit     na, nh, nc;
        a = -p0 + 3 * p1 - 3 * p2 + p3;
        h = p0 - 2 * p1 + p2;
        c = p1 - p0;
        na = a < 0;
        nh = h < 0;
        nc = c < 0;
        ma = magn(a);
        mh = magn(h);
        mc = magn(c);
        m = ma;
        if (mh > m) m = mh;
        if (mc > m) m = mc;
        if (m == 0) return;
        while (m >= (64'sd1 << 30)) begin
            m = m >>> 1; ma = ma >>> 1; mh = mh >>> 1; mc = mc >>> 1;
        end
        while (m < (64'sd1 << 29)) begin
            m = m << 1; ma = ma << 1; mh = mh << 1; mc = mc << 1;
        end
        a = na ? -ma : ma;
        h = nh ? -mh : mh;
        c = nc ? -mc : mc;
        if (a == 0) begin
            if (h != 0) push_param(-c, 2 * h, ts);
            return;
        end
        disc = h * h - a * c;
        if (disc < 0) return;
        s = 0;
        b = disc;
        bit_v = 64'sd1 << 62;
        while (bit_v > b) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (b >= s + bit_v) begin
                b = b - (s + bit_v);
                s = (s >>> 1) + bit_v;
            end else begin
                s = s >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        push_param(-h + s, a, ts);
        push_param(-h - s, a, ts);
    endfunction

    function automatic void clear_path();
        cur_x = 0; cur_y = 0; lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
        seeded = 1'b0;
    endfunction

    function automatic void track_command(cpbb_pkg::t_cmd_word w);
        longint ax, ay, bx, by, cx, cy;
        longint ts[$];
        cpbb_pkg::t_box_word bw;
        ax = w.pt_a_x; ay = w.pt_a_y;
        bx = w.pt_b_x; by = w.pt_b_y;
        cx = w.pt_c_x; cy = w.pt_c_y;
        if (w.req_type == cpbb_pkg::REQ_MOVE) begin
            cur_x = ax;
            cur_y = ay;
            if (!seeded) seed_box();
            else grow_box(ax, ay);
        end else if (w.req_type == cpbb_pkg::REQ_CURVE) begin
            seed_box();
            grow_box(cur_x, cur_y);
            grow_box(cx, cy);
            axis_extrema(cur_x, ax, bx, cx, ts);
            axis_extrema(cur_y, ay, by, cy, ts);
            foreach (ts[i])
                grow_box(curve_at(cur_x, ax, bx, cx, ts[i]),
                         curve_at(cur_y, ay, by, cy, ts[i]));
            cur_x = cx;
            cur_y = cy;
        end else begin
            seed_box();
            grow_box(cur_x, cur_y);
            grow_box(ax, ay);
            cur_x = ax;
            cur_y = ay;
        end
        if (w.last_command) begin
            bw.box_min_x = lo_x[31:0];
            bw.box_min_y = lo_y[31:0];
            bw.box_max_x = hi_x[31:0];
            bw.box_max_y = hi_y[31:0];
            box_queue = {box_queue, bw};
            clear_path();
        end
    endfunction

    // Drives one command word and waits until it is taken. Valid stays high
    // after the accept until the next call drives a new word or idles.
    task automatic send_word(cpbb_pkg::t_cmd_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        track_command(w);
    endtask

    task automatic send_checked(cpbb_pkg::t_cmd_word w, cpbb_pkg::t_box_word want);
        send_word(w);
        if (box_queue.size() == 0 || box_queue[$] !== want) begin
            $display("%0t table row box mismatch: expected %h actual %h", $time, want,
                     box_queue.size() ? box_queue[$] : '0);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(16'hffff) - 32'h8000;
            3: return ($urandom_range(400) - 200) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic cpbb_pkg::t_cmd_word rand_word(bit last_cmd);
        cpbb_pkg::t_cmd_word w;
        w.req_type = 2'($urandom_range(3));
        w.pt_a_x = rand_coord();
        w.pt_a_y = rand_coord();
        w.pt_b_x = rand_coord();
        w.pt_b_y = rand_coord();
        w.pt_c_x = rand_coord();
        w.pt_c_y = rand_coord();
        w.last_command = last_cmd;
        return w;
    endfunction

    // Output side: random stalls, one long hold-off, and the result check.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (box_queue.size() == 0) begin
                    $display("%0t unexpected box word: actual %h", $time, o_out_word);
                    fail_count++;
                end else begin
                    if (o_out_word.box_min_x !== box_queue[0].box_min_x
                        || o_out_word.box_min_y !== box_queue[0].box_min_y
                        || o_out_word.box_max_x !== box_queue[0].box_max_x
                        || o_out_word.box_max_y !== box_queue[0].box_max_y) begin
                        $display("%0t box mismatch: expected %h actual %h", $time,
                                 box_queue[0], o_out_word);
                        fail_count++;
                    end
                    void'(box_queue.pop_front());
                end
            end
            i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int hold_cycles;
        recv_hold = 1'b0;
        wait (send_idle_pct == 70 && recv_idle_pct == 19);
        @(posedge i_clk);
        recv_hold = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
            @(posedge i_clk);
            hold_cycles++;
        end
        recv_hold = 1'b0;
    end

    initial begin
        #50ms;
        $display("FAIL cubic_path_bounding_box");
        $finish;
    end

    initial begin
        cpbb_pkg::t_cmd_word w;
        cpbb_pkg::t_box_word b;
        int                  wait_cycles;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clear_path();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: close after reset, extremes, every command, curve cases.
        begin
            cpbb_pkg::t_cmd_word tbl[$];
            bit                  has_box[$];
            cpbb_pkg::t_box_word boxes[$];
            cpbb_pkg::t_box_word nb;
            nb = '0;
            w = '0; w.req_type = cpbb_pkg::REQ_CLOSE; w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b1}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_LINE; w.pt_a_x = 32'h7fff_ffff;
            w.pt_a_y = 32'h8000_0000; w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b1};
            b.box_min_x = 0; b.box_min_y = 32'h8000_0000;
            b.box_max_x = 32'h7fff_ffff; b.box_max_y = 0;
            boxes = {boxes, b};
            w = '0; w.req_type = cpbb_pkg::REQ_MOVE; w.pt_a_x = 32'h8000_0000;
            w.pt_a_y = 32'h7fff_ffff; w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b1};
            b.box_min_x = 32'h8000_0000; b.box_min_y = 32'h7fff_ffff;
            b.box_max_x = 32'h8000_0000; b.box_max_y = 32'h7fff_ffff;
            boxes = {boxes, b};
            w = '0; w.req_type = cpbb_pkg::REQ_MOVE; w.pt_a_x = 32'h0001_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_MOVE; w.pt_a_x = -32'sh0003_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            // Symmetric arch: one interior extremum in y.
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_y = 32'h0004_0000;
            w.pt_b_x = 32'h0004_0000; w.pt_b_y = 32'h0004_0000;
            w.pt_c_x = 32'h0004_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            // S curve: two extrema per axis.
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_x = 32'h0010_0000;
            w.pt_a_y = -32'sh0008_0000; w.pt_b_x = -32'sh0010_0000;
            w.pt_b_y = 32'h0008_0000; w.pt_c_x = 32'h0002_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            // Degenerate curve (all points equal) and a straight-line curve.
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_x = 32'h0002_0000;
            w.pt_b_x = 32'h0002_0000; w.pt_c_x = 32'h0002_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_x = 32'h0003_0000;
            w.pt_b_x = 32'h0004_0000; w.pt_c_x = 32'h0005_0000;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_CLOSE; w.pt_a_x = 32'hffff_ffff;
            w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            // Full-range curves with all bits set and cleared.
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_x = 32'h7fff_ffff;
            w.pt_a_y = 32'h8000_0000; w.pt_b_x = 32'h8000_0000;
            w.pt_b_y = 32'h7fff_ffff; w.pt_c_x = 32'hffff_ffff;
            w.pt_c_y = 32'h7fff_ffff; w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_LINE; w.pt_a_x = 32'h5555_5555;
            w.pt_a_y = 32'haaaa_aaaa;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            w = '0; w.req_type = cpbb_pkg::REQ_CURVE; w.pt_a_x = 32'haaaa_aaaa;
            w.pt_a_y = 32'h5555_5555; w.pt_b_x = 32'h8000_0001;
            w.pt_b_y = 32'h7fff_fffe; w.pt_c_x = 32'h0000_0001;
            w.pt_c_y = 32'hffff_fffe; w.last_command = 1'b1;
            tbl = {tbl, w}; has_box = {has_box, 1'b0}; boxes = {boxes, nb};
            foreach (tbl[i]) begin
                if (has_box[i]) send_checked(tbl[i], boxes[i]);
                else send_word(tbl[i]);
            end
        end

        // Random paths: a move, a few commands, and a last one; sometimes a
        // stray command opens a path without a move.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 19 : 0;
            for (int n = 0; n < 280; ) begin
                int len;
                len = $urandom_range(6);
                if ($urandom_range(9) != 0) begin
                    w = rand_word(1'b0);
                    w.req_type = cpbb_pkg::REQ_MOVE;
                    send_word(w);
                    n++;
                end
                for (int k = 0; k <= len; k++) begin
                    w = rand_word(k == len);
                    send_word(w);
                    n++;
                end
            end
            // Let the block drain before the next phase.
            i_in_valid <= 1'b0;
            wait_cycles = 0;
            do begin
                @(posedge i_clk);
                wait_cycles++;
            end while (box_queue.size() != 0 && wait_cycles < 400000);
        end

        repeat (300) @(posedge i_clk);
        if (box_queue.size() == 0 && fail_count == 0) begin
            $display("PASS cubic_path_bounding_box");
        end else begin
            if (box_queue.size() != 0)
                $display("%0t %0d box words never arrived", $time, box_queue.size());
            $display("FAIL cubic_path_bounding_box");
        end
        $finish;
    end

endmodule
